// ===== hdl/sha256_hash_engine_top_macros.svh =====
// Assertion macros for the SHA-256 hash engine.
`ifndef SHA256_HASH_ENGINE_TOP_MACROS_SVH
`define SHA256_HASH_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SHA256_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SHA256_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SHA256_ASSERT(label, prop, msg)
`define SHA256_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/sha256_pkg.sv =====
// Constants, tables and round functions of the SHA-256 hash engine.
package sha256_pkg;

	localparam int unsigned WordW   = 32;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned IdxW    = 3;
	localparam logic [ByteW-1:0] PadByte = 8'h80;

	localparam logic [WordW-1:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [WordW-1:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic logic [WordW-1:0] choose(input logic [WordW-1:0] e,
		input logic [WordW-1:0] f, input logic [WordW-1:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [WordW-1:0] majority(input logic [WordW-1:0] a,
		input logic [WordW-1:0] b, input logic [WordW-1:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

// ===== hdl/sha256_ifs.sv =====
// Handshake channel interfaces for message bytes and digest words.
interface sha256_msg_if;
	import sha256_pkg::*;
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] msg_byte;
	logic             has_byte;
	logic             end_of_message;
	modport source(output valid, output msg_byte, output has_byte, output end_of_message,
		input ready);
	modport sink(input valid, input msg_byte, input has_byte, input end_of_message,
		output ready);
endinterface

interface sha256_digest_if;
	import sha256_pkg::*;
	logic             valid;
	logic             ready;
	logic [WordW-1:0] digest_word;
	logic [IdxW-1:0]  word_index;
	logic             last_word;
	modport source(output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink(input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

// ===== hdl/sha256_hash_engine_top.sv =====
// SHA-256 hash engine: byte stream in, eight digest words out per message.
// Byte items are accepted only while idle; the 64th byte of a block starts a compression
// (load from the block memory and chain memory, 64 rounds, chain-memory update).
// End of message: padding words are written and compressed, plus a second padded block
// when 56 or more bytes are pending; then words go out one at a time, held by a stall.
// arst_n clears control state and the chain valid bits; no memory clearing pass.
`include "sha256_hash_engine_top_macros.svh"

module sha256_hash_engine_top (
	input logic clk,
	input logic arst_n,
	sha256_msg_if.sink msg,
	sha256_digest_if.source digest
);
	import sha256_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_LOAD  = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_ADD   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		MD_BLOCK,
		MD_BLOCK_EOM,
		MD_PAD_MORE,
		MD_PAD_LAST
	} mode_t;

	state_t      st_q;
	mode_t       mode_q;
	logic [5:0]  fill_q;
	logic [60:0] len_q;
	logic [3:0]  pw_q;
	logic        pad_first_q;
	logic [4:0]  cnt_q;
	logic [5:0]  rnd_q;
	logic [7:0]  chain_vld_q;
	logic [3:0]  e_q;
	logic        rd_pend_q;
	logic        out_valid_q;

	logic [WordW-1:0] word_q;
	logic [WordW-1:0] v_q [8];
	logic [WordW-1:0] w_q [16];
	logic [WordW-1:0] out_word_q;
	logic [IdxW-1:0]  out_idx_q;
	logic             out_last_q;

	logic [WordW-1:0] bmem [16];
	logic [WordW-1:0] bm_rdata_q;
	logic [WordW-1:0] cmem [8];
	logic [WordW-1:0] cm_rdata_q;
	logic [2:0]       cm_raddr_q;
	logic             cm_rvld_q;

	logic             accept;
	logic [5:0]       fill_nxt;
	logic [WordW-1:0] byte_word;
	logic [WordW-1:0] pad_word;
	logic [WordW-1:0] pad_data;
	logic [63:0]      len_bits;
	logic             bm_we;
	logic [3:0]       bm_waddr;
	logic [WordW-1:0] bm_wdata;
	logic             bm_re;
	logic             em_issue;
	logic             cm_re;
	logic [2:0]       cm_raddr;
	logic             cm_we;
	logic [2:0]       cm_waddr;
	logic [WordW-1:0] c_rdata;
	logic [WordW-1:0] cm_wdata;
	logic             load_push;
	logic             load_chain;
	logic [WordW-1:0] t1;
	logic [WordW-1:0] t2;
	logic [WordW-1:0] w_new;

	assign msg.ready = (st_q == ST_IDLE);
	assign accept    = msg.valid && msg.ready;
	assign fill_nxt  = msg.has_byte ? 6'(fill_q + 6'd1) : fill_q;
	assign byte_word = {word_q[23:0], msg.msg_byte};
	assign len_bits  = {len_q, 3'b000};

	always_comb begin
		unique case (fill_q[1:0])
			2'd0: pad_word = {PadByte, 24'd0};
			2'd1: pad_word = {word_q[7:0], PadByte, 16'd0};
			2'd2: pad_word = {word_q[15:0], PadByte, 8'd0};
			2'd3: pad_word = {word_q[23:0], PadByte};
		endcase
	end

	always_comb begin
		if (pad_first_q) begin
			pad_data = pad_word;
		end else if (mode_q == MD_PAD_LAST && pw_q == 4'd14) begin
			pad_data = len_bits[63:32];
		end else if (mode_q == MD_PAD_LAST && pw_q == 4'd15) begin
			pad_data = len_bits[31:0];
		end else begin
			pad_data = '0;
		end
	end

	// block buffer memory: one word per four bytes
	assign bm_we    = (accept && msg.has_byte && fill_q[1:0] == 2'b11) || (st_q == ST_PAD);
	assign bm_waddr = (st_q == ST_PAD) ? pw_q : fill_q[5:2];
	assign bm_wdata = (st_q == ST_PAD) ? pad_data : byte_word;
	assign bm_re    = (st_q == ST_LOAD) && !cnt_q[4];

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bmem[bm_waddr] <= bm_wdata;
		end
		if (bm_re) begin
			bm_rdata_q <= bmem[cnt_q[3:0]];
		end
	end

	// chain state memory; an entry not written since restart reads as the initial value
	assign em_issue = (st_q == ST_EMIT) && !e_q[3] && !rd_pend_q && (!out_valid_q || digest.ready);
	assign cm_re    = ((st_q == ST_LOAD || st_q == ST_ADD) && cnt_q[4:3] == 2'b00) || em_issue;
	assign cm_raddr = (st_q == ST_EMIT) ? e_q[2:0] : cnt_q[2:0];
	assign cm_we    = (st_q == ST_ADD) && (cnt_q != 5'd0);
	assign cm_waddr = 3'(cnt_q - 5'd1);
	assign c_rdata  = cm_rvld_q ? cm_rdata_q : INIT_H[cm_raddr_q];
	assign cm_wdata = c_rdata + v_q[0];

	always_ff @(posedge clk) begin
		if (cm_we) begin
			cmem[cm_waddr] <= cm_wdata;
		end
		if (cm_re) begin
			cm_rdata_q <= cmem[cm_raddr];
			cm_raddr_q <= cm_raddr;
			cm_rvld_q  <= chain_vld_q[cm_raddr];
		end
	end

	// round datapath
	assign t1 = v_q[7] + big_sigma1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6])
		+ ROUND_K[rnd_q] + w_q[0];
	assign t2 = big_sigma0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);
	assign w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];

	assign load_push  = (st_q == ST_LOAD) && (cnt_q != 5'd0);
	assign load_chain = load_push && (cnt_q <= 5'd8);

	always_ff @(posedge clk) begin
		if (accept && msg.has_byte) begin
			word_q <= byte_word;
		end
		if (load_push) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= bm_rdata_q;
		end else if (st_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
		if (load_chain || cm_we) begin
			for (int i = 0; i < 7; i++) begin
				v_q[i] <= v_q[i+1];
			end
			v_q[7] <= c_rdata;
		end else if (st_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (rd_pend_q) begin
			out_word_q <= c_rdata;
			out_idx_q  <= cm_raddr_q;
			out_last_q <= (cm_raddr_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			mode_q      <= MD_BLOCK;
			fill_q      <= '0;
			len_q       <= '0;
			pw_q        <= '0;
			pad_first_q <= 1'b0;
			cnt_q       <= '0;
			rnd_q       <= '0;
			chain_vld_q <= '0;
			e_q         <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= em_issue;
			if (rd_pend_q) begin
				out_valid_q <= 1'b1;
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cm_we) begin
				chain_vld_q[cm_waddr] <= 1'b1;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q <= fill_nxt;
						if (msg.has_byte) begin
							len_q <= 61'(len_q + 61'd1);
						end
						if (msg.has_byte && fill_q == 6'd63) begin
							st_q   <= ST_LOAD;
							cnt_q  <= '0;
							mode_q <= msg.end_of_message ? MD_BLOCK_EOM : MD_BLOCK;
						end else if (msg.end_of_message) begin
							st_q        <= ST_PAD;
							pw_q        <= fill_nxt[5:2];
							pad_first_q <= 1'b1;
							mode_q      <= (fill_nxt >= 6'd56) ? MD_PAD_MORE : MD_PAD_LAST;
						end
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					pw_q        <= pw_q + 4'd1;
					if (pw_q == 4'd15) begin
						st_q  <= ST_LOAD;
						cnt_q <= '0;
					end
				end
				ST_LOAD: begin
					if (cnt_q == 5'd16) begin
						st_q  <= ST_ROUND;
						cnt_q <= '0;
						rnd_q <= '0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						st_q  <= ST_ADD;
						cnt_q <= '0;
					end
				end
				ST_ADD: begin
					if (cnt_q == 5'd8) begin
						cnt_q <= '0;
						unique case (mode_q)
							MD_BLOCK: begin
								st_q <= ST_IDLE;
							end
							MD_BLOCK_EOM: begin
								st_q        <= ST_PAD;
								pw_q        <= '0;
								pad_first_q <= 1'b1;
								mode_q      <= MD_PAD_LAST;
							end
							MD_PAD_MORE: begin
								st_q        <= ST_PAD;
								pw_q        <= '0;
								pad_first_q <= 1'b0;
								mode_q      <= MD_PAD_LAST;
							end
							MD_PAD_LAST: begin
								st_q <= ST_EMIT;
								e_q  <= '0;
							end
						endcase
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_EMIT: begin
					if (em_issue) begin
						e_q <= e_q + 4'd1;
					end
					// last word captured: restart from the initial hash values
					if (rd_pend_q && cm_raddr_q == 3'd7) begin
						st_q        <= ST_IDLE;
						chain_vld_q <= '0;
						fill_q      <= '0;
						len_q       <= '0;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign digest.valid       = out_valid_q;
	assign digest.digest_word = out_word_q;
	assign digest.word_index  = out_idx_q;
	assign digest.last_word   = out_last_q;

	`SHA256_ASSERT_NEXT(a_round_exit, rnd_q == 6'd63, st_q == ST_ADD, "rounds overran")
	`SHA256_ASSERT(a_pend_emit, rd_pend_q |-> (st_q == ST_EMIT), "read pending outside emit")
	`SHA256_ASSERT(a_out_src, $rose(out_valid_q) |-> $past(st_q == ST_EMIT), "word outside emit")
	`SHA256_ASSERT_NEXT(a_pad_load, st_q == ST_PAD && pw_q == 4'd15, st_q == ST_LOAD, "no load")

endmodule

// ===== test/sha256_hash_engine_checker.sv =====
// Checker for the SHA-256 hash engine: watches both channels, predicts digests, compares.
`timescale 1ns / 100ps

module sha256_hash_engine_checker (
	input logic clk,
	input logic arst_n,
	sha256_msg_if msg,
	sha256_digest_if digest,
	output int fail_count,
	output int words_pending,
	output int items_taken,
	output int messages_done,
	output int words_checked
);
	import sha256_pkg::*;

	typedef struct packed {
		logic [WordW-1:0] word;
		logic [IdxW-1:0]  idx;
		logic             last;
	} digest_word_t;

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [31:0]  chain [8];
	logic [7:0]   blk [64];
	int unsigned  fill;
	logic [63:0]  bit_count;
	digest_word_t digest_q [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic restart_hash();
		chain = HASH_IV;
		fill = 0;
		bit_count = '0;
	endtask

	task automatic mix_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wt, s0, s1;
		int r;
		for (r = 0; r < 16; r++)
			w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
		{a, b, c, d} = {chain[0], chain[1], chain[2], chain[3]};
		{e, f, g, h} = {chain[4], chain[5], chain[6], chain[7]};
		for (r = 0; r < 64; r++) begin
			if (r < 16) begin
				wt = w[r];
			end else begin
				s0 = ror(w[(r-15)&15], 7) ^ ror(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
				s1 = ror(w[(r-2)&15], 17) ^ ror(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
				wt = s1 + w[(r-7)&15] + s0 + w[r&15];
				w[r&15] = wt;
			end
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_CONST[r] + wt;
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g;
			g = f;
			f = e;
			e = d + t1;
			d = c;
			c = b;
			b = a;
			a = t1 + t2;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
		chain[5] += f;
		chain[6] += g;
		chain[7] += h;
	endtask

	// pad with 0x80, zeros and the 64-bit length; spills into a second block past 55 bytes
	task automatic seal_message();
		logic [63:0] total;
		int k;
		total = bit_count + 64'(fill * 8);
		blk[fill] = 8'h80;
		k = fill + 1;
		if (k > 56) begin
			while (k < 64) begin
				blk[k] = 8'h00;
				k++;
			end
			mix_block();
			k = 0;
		end
		while (k < 56) begin
			blk[k] = 8'h00;
			k++;
		end
		for (k = 0; k < 8; k++)
			blk[63-k] = total[8*k +: 8];
		mix_block();
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (fail_count < 50)
			$display("%0t mismatch %s: got %h want %h (message %0d)",
				$time, what, got, want, messages_done);
		fail_count++;
	endtask

	task automatic take_item();
		int i;
		items_taken++;
		if (msg.has_byte) begin
			blk[fill] = msg.msg_byte;
			fill++;
			if (fill == 64) begin
				mix_block();
				bit_count += 64'd512;
				fill = 0;
			end
		end
		if (msg.end_of_message) begin
			seal_message();
			for (i = 0; i < 8; i++)
				digest_q.push_back('{word: chain[i], idx: IdxW'(i), last: (i == 7)});
			messages_done++;
			restart_hash();
		end
	endtask

	task automatic check_word();
		digest_word_t want;
		if (digest_q.size() == 0) begin
			flag_mismatch("unexpected digest word", digest.digest_word, 32'h0);
			return;
		end
		want = digest_q.pop_front();
		words_checked++;
		if (digest.digest_word !== want.word)
			flag_mismatch("digest_word", digest.digest_word, want.word);
		if (digest.word_index !== want.idx)
			flag_mismatch("word_index", 32'(digest.word_index), 32'(want.idx));
		if (digest.last_word !== want.last)
			flag_mismatch("last_word", 32'(digest.last_word), 32'(want.last));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			restart_hash();
			digest_q.delete();
			fail_count = 0;
			items_taken = 0;
			messages_done = 0;
			words_checked = 0;
		end else begin
			if (digest.valid && digest.ready)
				check_word();
			if (msg.valid && msg.ready)
				take_item();
		end
		words_pending = digest_q.size();
	end

endmodule

// ===== test/tb_sha256_hash_engine_top.sv =====
// Testbench top for the SHA-256 hash engine: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb_sha256_hash_engine_top;
	import sha256_pkg::*;

	localparam int RANDOM_ITEMS = 230;
	localparam int RX_HOLD      = 400;
	localparam int DRAIN_CYCLES = 250;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int EDGE_LEN [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

	logic clk = 1'b0;
	logic arst_n;
	logic tx_steady = 1'b0;
	logic rx_steady = 1'b0;
	logic rx_hold_req = 1'b0;
	int   fail_count, words_pending, items_taken, messages_done, words_checked;
	int   cycles = 0;

	sha256_msg_if    msg_ch();
	sha256_digest_if digest_ch();

	sha256_hash_engine_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (digest_ch)
	);

	sha256_hash_engine_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.msg           (msg_ch),
		.digest        (digest_ch),
		.fail_count    (fail_count),
		.words_pending (words_pending),
		.items_taken   (items_taken),
		.messages_done (messages_done),
		.words_checked (words_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_item(input logic [7:0] b, input logic hb, input logic eom);
		@(negedge clk);
		while (!tx_steady && $urandom_range(0, 99) < 37) begin
			msg_ch.valid <= 1'b0;
			msg_ch.msg_byte <= 8'($urandom_range(0, 255));
			@(negedge clk);
		end
		msg_ch.valid <= 1'b1;
		msg_ch.msg_byte <= b;
		msg_ch.has_byte <= hb;
		msg_ch.end_of_message <= eom;
		@(posedge clk);
		while (!msg_ch.ready)
			@(posedge clk);
	endtask

	task automatic hold_for_digests();
		@(negedge clk);
		msg_ch.valid <= 1'b0;
		wait (words_pending == 0);
	endtask

	// receiver: random stalls, quiet stretches, and one long hold-off counted here
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		digest_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				hold_left = RX_HOLD;
				rx_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				digest_ch.ready <= 1'b0;
			end else begin
				digest_ch.ready <= rx_steady || ($urandom_range(0, 99) >= 37);
			end
		end
	end

	initial begin : watchdog
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d digest words outstanding",
					cycles, words_pending);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int sent, len, pick, k;
		logic end_with_byte, in_hold, hold_done;
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.msg_byte = 8'h00;
		msg_ch.has_byte = 1'b0;
		msg_ch.end_of_message = 1'b0;
		in_hold = 1'b0;
		hold_done = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty message, ignored items, extreme bytes, "abc", end without byte
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'ha5, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'h5a, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'hc3, 1'b0, 1'b1);
		send_item(8'h7e, 1'b0, 1'b1);
		send_item(8'h81, 1'b0, 1'b1);
		hold_for_digests();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (!hold_done && sent >= 110) begin
				hold_done = 1'b1;
				in_hold = 1'b1;
				rx_hold_req = 1'b1;
			end
			if (in_hold && sent >= 160) begin
				in_hold = 1'b0;
				hold_for_digests();
			end
			tx_steady = in_hold || (sent >= 40 && sent < 90);
			rx_steady = (sent >= 40 && sent < 90);

			pick = $urandom_range(0, 99);
			if (in_hold || pick < 62)
				len = $urandom_range(0, 8);
			else if (pick < 86)
				len = EDGE_LEN[$urandom_range(0, 9)];
			else
				len = $urandom_range(9, 80);
			end_with_byte = 1'($urandom_range(0, 1));

			for (k = 0; k < len; k++) begin
				if ($urandom_range(0, 99) < 8)
					send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
				send_item(8'($urandom_range(0, 255)), 1'b1,
					end_with_byte && (k == len - 1));
				sent++;
			end
			if (len == 0 || !end_with_byte) begin
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
				sent++;
			end
		end

		hold_for_digests();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Fed %0d items forming %0d messages, empty through multi-block lengths;",
			items_taken, messages_done);
		$display("checked %0d digest words under random stalls and a %0d-cycle output hold.",
			words_checked, RX_HOLD);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
